[design/dvtu_pkg.sv]
// ----------------------------------------------------------------------------
// Distance-vector table update: shared package
// Widths, action codes, the token that walks the cell chain, and helpers.
// ----------------------------------------------------------------------------
package dvtu_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int ADDR_W      = 32;
  localparam int COST_W      = 8;
  localparam int OUT_IDX_W   = 6;

  typedef logic [1:0] action_t;

  localparam action_t ACT_INSERTED = 2'd0;
  localparam action_t ACT_UPDATED  = 2'd1;
  localparam action_t ACT_KEPT     = 2'd2;
  localparam action_t ACT_DROPPED  = 2'd3;

  // Query and result travelling together along the row of cells.
  typedef struct packed {
    logic               last;
    logic [ADDR_W-1:0]  dest;
    logic [COST_W-1:0]  new_cost;
    logic [ADDR_W-1:0]  sender;
    logic [ADDR_W-1:0]  iface;
    logic               done;
    action_t            action;
    logic [IDX_W-1:0]   slot;
    logic [COST_W-1:0]  cost;
    logic [ADDR_W-1:0]  hop;
    logic               changed;
  } tok_t;

  // The reported slot is the table slot taken modulo 64.
  function automatic logic [OUT_IDX_W-1:0] slot_to_out(input logic [IDX_W-1:0] slot);
    logic [IDX_W+OUT_IDX_W-1:0] wide;
    begin
      wide = {{OUT_IDX_W{1'b0}}, slot};
      return wide[OUT_IDX_W-1:0];
    end
  endfunction

endpackage

[design/dvtu_cell.sv]
// ----------------------------------------------------------------------------
// Distance-vector table update: route cell
// Holds one table slot and relaxes or fills it as the token passes by.
// ----------------------------------------------------------------------------
module dvtu_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [dvtu_pkg::IDX_W-1:0] cell_idx,
  input  logic [dvtu_pkg::CNT_W-1:0] entry_count,
  input  logic                      tok_in_vld,
  input  dvtu_pkg::tok_t            tok_in,
  output logic                      tok_out_vld,
  output dvtu_pkg::tok_t            tok_out
);

  logic [dvtu_pkg::ADDR_W-1:0] dest_r;
  logic [dvtu_pkg::ADDR_W-1:0] hop_r;
  logic [dvtu_pkg::ADDR_W-1:0] iface_r;
  logic [dvtu_pkg::COST_W-1:0] cost_r;
  logic                        vld_r;
  dvtu_pkg::tok_t              tok_r;
  dvtu_pkg::tok_t              tok_nxt;
  logic                        occ;
  logic                        look;
  logic                        hit;
  logic                        ins;
  logic                        upd;

  always_comb begin
    occ  = dvtu_pkg::CNT_W'(cell_idx) < entry_count;
    look = tok_in_vld && !tok_in.done;
    hit  = look && occ && (dest_r == tok_in.dest);
    ins  = look && !occ;
    upd  = hit && ((cost_r > tok_in.new_cost) || (hop_r == tok_in.sender)) &&
           ((cost_r != tok_in.new_cost) || (hop_r != tok_in.sender));

    tok_nxt = tok_in;
    if (hit) begin
      tok_nxt.done    = 1'b1;
      tok_nxt.slot    = cell_idx;
      tok_nxt.action  = upd ? dvtu_pkg::ACT_UPDATED : dvtu_pkg::ACT_KEPT;
      tok_nxt.cost    = upd ? tok_in.new_cost : cost_r;
      tok_nxt.hop     = upd ? tok_in.sender : hop_r;
      tok_nxt.changed = upd;
    end else if (ins) begin
      tok_nxt.done    = 1'b1;
      tok_nxt.slot    = cell_idx;
      tok_nxt.action  = dvtu_pkg::ACT_INSERTED;
      tok_nxt.cost    = tok_in.new_cost;
      tok_nxt.hop     = tok_in.sender;
      tok_nxt.changed = 1'b1;
    end
  end

  // The interface of a learned route is kept with the slot; the update
  // itself never reads it back.
  always_ff @(posedge clk) begin
    if (upd || ins) begin
      cost_r <= tok_in.new_cost;
      hop_r  <= tok_in.sender;
    end
    if (ins) begin
      dest_r  <= tok_in.dest;
      iface_r <= tok_in.iface;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= tok_in_vld;
    end
  end

  always_ff @(posedge clk) begin
    tok_r <= tok_nxt;
  end

  assign tok_out_vld = vld_r;
  assign tok_out     = tok_r;

endmodule

[design/distance_vector_table_update.sv]
// ----------------------------------------------------------------------------
// Distance-vector table update
// Bellman-Ford relaxation of one advertised route against a 64-slot table.
// ----------------------------------------------------------------------------
// Usage. Each input beat on the in_ channel carries one advertised route
// (destination and cost) with the sender, the receiving interface and a
// last-of-message flag. Each input beat gives exactly one result beat on the
// out_ channel: the action taken, the slot, the cost and next hop now held in
// that slot, and on the last beat of a message whether any slot changed
// during that message.
// The table is a row of identical cells, one per slot. An accepted beat
// becomes a token that steps through one cell per clock; the first occupied
// cell whose destination matches relaxes itself, otherwise the first free
// cell takes the new route. A token that leaves the row unserved means the
// table is full and the route is dropped.
// A result beat follows its input beat once the token has walked the whole
// cell row; one item is in the row at a time, so the block takes no new
// input beat until the previous token has left the pending register.
// A finished result waits in the output register while the next input beat
// is accepted; if the receiver stalls, the row holds its finished token in a
// pending register and in_ready stays low until the result moves on.
// Reset (rst_n low, synchronous) empties the table and the change flag and
// sets cost_limit to 255; no clearing pass is needed. cfg_ is always ready
// and must be written only while the block is idle.
// ----------------------------------------------------------------------------
module distance_vector_table_update (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_cost_limit,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_adv_destination,
  input  logic [7:0]  in_adv_cost,
  input  logic [31:0] in_sender_address,
  input  logic [31:0] in_receive_interface,
  input  logic        in_last_of_message,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_action,
  output logic [5:0]  out_entry_index,
  output logic [7:0]  out_route_cost,
  output logic [31:0] out_route_next_hop,
  output logic        out_message_changed
);

  localparam int N = dvtu_pkg::TABLE_DEPTH;

  logic [dvtu_pkg::COST_W-1:0] cost_limit_r;
  logic [dvtu_pkg::CNT_W-1:0]  count_r;
  logic                        change_seen_r;
  logic                        change_nxt;
  logic                        busy_r;
  logic                        pend_vld_r;
  dvtu_pkg::tok_t              pend_r;
  dvtu_pkg::tok_t              pend_nxt;
  logic                        in_fire;
  logic                        load_out;
  logic [dvtu_pkg::COST_W:0]   cost_sum;
  dvtu_pkg::tok_t              head_tok;

  logic                        out_valid_r;
  dvtu_pkg::action_t           out_action_r;
  logic [5:0]                  out_entry_index_r;
  logic [7:0]                  out_route_cost_r;
  logic [31:0]                 out_route_next_hop_r;
  logic                        out_message_changed_r;

  // Token links between neighbouring cells; link 0 is the head of the row.
  logic                        link_vld [0:N];
  dvtu_pkg::tok_t              link_tok [0:N];

  assign cfg_ready = 1'b1;
  assign in_ready  = !busy_r;
  assign in_fire   = in_valid && in_ready;
  assign load_out  = pend_vld_r && (!out_valid_r || out_ready);

  // The new cost is the advertised cost plus one, without wrap, then limited.
  always_comb begin
    cost_sum = {1'b0, in_adv_cost} + {{dvtu_pkg::COST_W{1'b0}}, 1'b1};
    head_tok          = '0;
    head_tok.last     = in_last_of_message;
    head_tok.dest     = in_adv_destination;
    head_tok.sender   = in_sender_address;
    head_tok.iface    = in_receive_interface;
    head_tok.new_cost = (cost_sum > {1'b0, cost_limit_r}) ? cost_limit_r :
                        cost_sum[dvtu_pkg::COST_W-1:0];
    head_tok.action   = dvtu_pkg::ACT_DROPPED;
  end

  assign link_vld[0] = in_fire;
  assign link_tok[0] = head_tok;

  for (genvar i = 0; i < N; i++) begin : g_cell
    dvtu_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .cell_idx    (dvtu_pkg::IDX_W'(i)),
      .entry_count (count_r),
      .tok_in_vld  (link_vld[i]),
      .tok_in      (link_tok[i]),
      .tok_out_vld (link_vld[i+1]),
      .tok_out     (link_tok[i+1])
    );
  end

  // Change tracking over one message, counting the closing beat itself.
  assign change_nxt = change_seen_r || link_tok[N].changed;

  // The pending token carries the message flag in place of the per-beat one.
  always_comb begin
    pend_nxt         = link_tok[N];
    pend_nxt.changed = link_tok[N].last && change_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cost_limit_r  <= 8'd255;
      count_r       <= '0;
      change_seen_r <= 1'b0;
      busy_r        <= 1'b0;
      pend_vld_r    <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        cost_limit_r <= cfg_cost_limit;
      end
      if (in_fire) begin
        busy_r <= 1'b1;
      end else if (load_out) begin
        busy_r <= 1'b0;
      end
      if (link_vld[N]) begin
        pend_vld_r    <= 1'b1;
        change_seen_r <= link_tok[N].last ? 1'b0 : change_nxt;
        if (link_tok[N].action == dvtu_pkg::ACT_INSERTED) begin
          count_r <= count_r + dvtu_pkg::CNT_W'(1);
        end
      end else if (load_out) begin
        pend_vld_r <= 1'b0;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (link_vld[N]) begin
      pend_r <= pend_nxt;
    end
    if (load_out) begin
      out_action_r          <= pend_r.action;
      out_entry_index_r     <= dvtu_pkg::slot_to_out(pend_r.slot);
      out_route_cost_r      <= pend_r.cost;
      out_route_next_hop_r  <= pend_r.hop;
      out_message_changed_r <= pend_r.changed;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_action          = out_action_r;
  assign out_entry_index     = out_entry_index_r;
  assign out_route_cost      = out_route_cost_r;
  assign out_route_next_hop  = out_route_next_hop_r;
  assign out_message_changed = out_message_changed_r;

endmodule

[design/dvtu_checker.sv]
// ----------------------------------------------------------------------------
// Distance-vector table update: port checker
// Watches the top level's ports and flags behaviour the block must not show.
// ----------------------------------------------------------------------------
module dvtu_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic [7:0]  cfg_cost_limit,
  input logic        in_valid,
  input logic        in_ready,
  input logic [31:0] in_adv_destination,
  input logic [7:0]  in_adv_cost,
  input logic [31:0] in_sender_address,
  input logic [31:0] in_receive_interface,
  input logic        in_last_of_message,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_action,
  input logic [5:0]  out_entry_index,
  input logic [7:0]  out_route_cost,
  input logic [31:0] out_route_next_hop,
  input logic        out_message_changed
);

  // Reset leaves no result pending and the input side open.
  a_reset_clean: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("result or busy state survived reset");

  // Only one item walks the table at a time.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second beat accepted while the table walk runs");

  // A dropped route reports an empty slot.
  a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_action == dvtu_pkg::ACT_DROPPED |->
      out_entry_index == 6'd0 && out_route_cost == 8'd0 && out_route_next_hop == 32'd0)
    else $error("dropped route carries slot data");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_action) &&
      $stable(out_route_next_hop) && $stable(out_message_changed))
    else $error("stalled result changed");

endmodule

bind distance_vector_table_update dvtu_checker u_dvtu_checker (.*);

[verif/route_update_checker.sv]
// ----------------------------------------------------------------------------
// Route table update checker
// Keeps its own copy of the route table and the cost limit. It predicts the
// result of every accepted input beat and compares each result beat, field
// by field, with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module route_update_checker
  import dvtu_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [7:0]  cfg_cost_limit,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [31:0] in_adv_destination,
  input  logic [7:0]  in_adv_cost,
  input  logic [31:0] in_sender_address,
  input  logic [31:0] in_receive_interface,
  input  logic        in_last_of_message,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  out_action,
  input  logic [5:0]  out_entry_index,
  input  logic [7:0]  out_route_cost,
  input  logic [31:0] out_route_next_hop,
  input  logic        out_message_changed,
  output int          mismatches,
  output int          outstanding
);

  typedef struct packed {
    action_t              action;
    logic [OUT_IDX_W-1:0] index;
    logic [COST_W-1:0]    cost;
    logic [ADDR_W-1:0]    hop;
    logic                 changed;
  } route_result_t;

  logic [COST_W-1:0] limit_copy;
  int                routes_held;
  logic [ADDR_W-1:0] dest_tab  [TABLE_DEPTH];
  logic [ADDR_W-1:0] hop_tab   [TABLE_DEPTH];
  logic [ADDR_W-1:0] iface_tab [TABLE_DEPTH];
  logic [COST_W-1:0] cost_tab  [TABLE_DEPTH];
  logic              change_pending;
  route_result_t     awaited [$];
  int                errs = 0;

  // One relaxation step against the table copy; returns the result it causes.
  function automatic route_result_t relax_route(input logic [ADDR_W-1:0] dest,
                                                input logic [COST_W-1:0] adv,
                                                input logic [ADDR_W-1:0] sender,
                                                input logic [ADDR_W-1:0] iface,
                                                input logic              last);
    route_result_t     r;
    logic [COST_W:0]   wide_cost;
    logic [COST_W-1:0] offered;
    int                slot;
    r = '0;
    r.action = ACT_DROPPED;
    wide_cost = {1'b0, adv} + (COST_W + 1)'(1);
    offered = (wide_cost > {1'b0, limit_copy}) ? limit_copy : wide_cost[COST_W-1:0];
    slot = -1;
    for (int i = 0; i < routes_held; i++)
      if (slot < 0 && dest_tab[i] == dest) slot = i;
    if (slot >= 0) begin
      r.action = ACT_KEPT;
      r.index = slot[OUT_IDX_W-1:0];
      if (cost_tab[slot] > offered || hop_tab[slot] == sender) begin
        if (cost_tab[slot] != offered || hop_tab[slot] != sender) begin
          cost_tab[slot] = offered;
          hop_tab[slot] = sender;
          r.action = ACT_UPDATED;
          change_pending = 1'b1;
        end
      end
      r.cost = cost_tab[slot];
      r.hop = hop_tab[slot];
    end else if (routes_held < TABLE_DEPTH) begin
      dest_tab[routes_held] = dest;
      cost_tab[routes_held] = offered;
      hop_tab[routes_held] = sender;
      iface_tab[routes_held] = iface;
      r.action = ACT_INSERTED;
      r.index = routes_held[OUT_IDX_W-1:0];
      r.cost = offered;
      r.hop = sender;
      routes_held++;
      change_pending = 1'b1;
    end
    r.changed = last & change_pending;
    if (last) change_pending = 1'b0;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    route_result_t got;
    route_result_t want;
    if (!rst_n) begin
      limit_copy = 8'd255;
      routes_held = 0;
      change_pending = 1'b0;
      awaited.delete();
    end else begin
      if (out_valid && out_ready) begin
        got = {out_action, out_entry_index, out_route_cost, out_route_next_hop,
               out_message_changed};
        if (awaited.size() == 0) begin
          errs++;
          $display("%0t: unexpected result beat: action %0d slot %0d cost %0d hop %h chg %0b",
                   $time, got.action, got.index, got.cost, got.hop, got.changed);
        end else begin
          want = awaited.pop_front();
          if (got !== want) begin
            errs++;
            $display("%0t: expected action %0d slot %0d cost %0d hop %h chg %0b", $time,
                     want.action, want.index, want.cost, want.hop, want.changed);
            $display("%0t:      got action %0d slot %0d cost %0d hop %h chg %0b", $time,
                     got.action, got.index, got.cost, got.hop, got.changed);
          end
        end
      end
      if (in_valid && in_ready)
        awaited = {awaited, relax_route(in_adv_destination, in_adv_cost, in_sender_address,
                                        in_receive_interface, in_last_of_message)};
      if (cfg_valid && cfg_ready) limit_copy = cfg_cost_limit;
    end
    mismatches <= errs;
    outstanding <= awaited.size();
  end

endmodule

[verif/tb.sv]
// ----------------------------------------------------------------------------
// Distance-vector table update testbench
// Drives advertised routes into the block as neighbour messages, walks the
// cost limit through several settings, and leaves the prediction and the
// comparison of every result beat to the route update checker.
// ----------------------------------------------------------------------------
module tb;
  import dvtu_pkg::*;

  // Fixed neighbour addresses for the directed part; the extremes of the
  // address field appear as senders too.
  localparam logic [31:0] HOP_A = 32'h0A00_0001;
  localparam logic [31:0] HOP_B = 32'hC0A8_0102;
  localparam logic [31:0] HOP_C = 32'h0000_0000;
  localparam int          RANDOM_PER_PHASE = 175;

  logic        clk;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_cost_limit;
  logic        in_valid;
  logic        in_ready;
  logic [31:0] in_adv_destination;
  logic [7:0]  in_adv_cost;
  logic [31:0] in_sender_address;
  logic [31:0] in_receive_interface;
  logic        in_last_of_message;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_action;
  logic [5:0]  out_entry_index;
  logic [7:0]  out_route_cost;
  logic [31:0] out_route_next_hop;
  logic        out_message_changed;
  int          mismatches;
  int          outstanding;

  // Destinations already sent while the table still had room. Since every
  // new destination is inserted until the table is full, the size of this
  // queue follows the block's entry count exactly.
  logic [31:0] known_dests [$];
  logic [31:0] neighbours [4];
  logic [7:0]  phase_limits [5];
  int          routes_sent;

  distance_vector_table_update uut (.*);

  route_update_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog: far beyond the slowest legal run, even if every beat met the
  // longest sender gap and the longest receiver stall.
  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic bit is_known(input logic [31:0] dest);
    bit hit;
    hit = 1'b0;
    foreach (known_dests[i])
      if (known_dests[i] == dest) hit = 1'b1;
    return hit;
  endfunction

  // Mostly destinations the table already holds, so that relaxation is
  // exercised; fresh ones while there is room, and a trickle of fresh ones
  // once the table is full so that dropped beats keep appearing.
  function automatic logic [31:0] pick_dest();
    int roll;
    int fresh_pct;
    roll = $urandom_range(0, 99);
    fresh_pct = (known_dests.size() < TABLE_DEPTH) ? 35 : 8;
    if (known_dests.size() == 0 || roll < fresh_pct) return $urandom;
    if (roll < fresh_pct + 5) return $urandom_range(0, 3);
    return known_dests[$urandom_range(0, known_dests.size() - 1)];
  endfunction

  // Low costs dominate so that relaxation competes; the full range still
  // reaches the saturation against the limit.
  function automatic logic [7:0] pick_cost();
    if ($urandom_range(0, 9) < 7) return 8'($urandom_range(0, 12));
    return 8'($urandom_range(0, 255));
  endfunction

  // Most gaps are short, a few are long enough to span a whole table walk.
  function automatic int sender_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 10);
    if (roll < 98) return $urandom_range(11, 60);
    return $urandom_range(100, 300);
  endfunction

  task automatic idle_sender(input int cycles);
    if (cycles > 0) begin
      in_valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Offers one beat and holds it until the block takes it. Valid is left
  // high, so that a following beat can go out without a gap.
  task automatic send_route(input logic [31:0] dest, input logic [7:0] cost,
                            input logic [31:0] sender, input logic [31:0] iface,
                            input logic last);
    in_valid <= 1'b1;
    in_adv_destination <= dest;
    in_adv_cost <= cost;
    in_sender_address <= sender;
    in_receive_interface <= iface;
    in_last_of_message <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (!is_known(dest) && known_dests.size() < TABLE_DEPTH) known_dests = {known_dests, dest};
  endtask

  // Stops offering and waits until every predicted result has come back.
  // The first edge lets the checker count a beat taken at this very edge.
  task automatic drain_routes();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // The limit is only ever changed with the block idle.
  task automatic set_cost_limit(input logic [7:0] value);
    drain_routes();
    cfg_valid <= 1'b1;
    cfg_cost_limit <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // One neighbour message: a run of routes from a single sender with the
  // last flag on its final beat. About one message in ten is broken: each
  // beat from a random sender, with the last flag set at random.
  task automatic send_message();
    int          len;
    logic [31:0] hop;
    bit          calm;
    bit          broken;
    len = $urandom_range(1, 8);
    hop = ($urandom_range(0, 6) == 0) ? $urandom : neighbours[$urandom_range(0, 3)];
    calm = ($urandom_range(0, 3) == 0);
    broken = ($urandom_range(0, 9) == 0);
    for (int k = 0; k < len; k++) begin
      if (!calm) idle_sender(sender_gap());
      if (broken)
        send_route(pick_dest(), pick_cost(), $urandom, $urandom, $urandom_range(0, 3) == 0);
      else
        send_route(pick_dest(), pick_cost(), hop, $urandom, k == len - 1);
      routes_sent++;
    end
  endtask

  // Receiver: alternates between calm stretches, where every result beat is
  // taken at once, and choppy ones with short and occasional long stalls.
  // After 150 result beats it holds off once for a long stretch, while the
  // sender keeps offering, so that the block fills up and stalls its input.
  initial begin : receiver
    int  taken;
    int  stall_left;
    int  mode_left;
    bit  choppy;
    bit  held_long;
    taken = 0;
    stall_left = 0;
    mode_left = 0;
    choppy = 1'b0;
    held_long = 1'b0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) taken++;
      if (!held_long && taken >= 150) begin
        held_long = 1'b1;
        stall_left = 600;
      end
      if (mode_left == 0) begin
        mode_left = $urandom_range(20, 300);
        choppy = ($urandom_range(0, 2) != 0);
      end
      mode_left--;
      if (stall_left == 0 && choppy) begin
        if ($urandom_range(0, 19) == 0) stall_left = $urandom_range(30, 200);
        else if ($urandom_range(0, 2) == 0) stall_left = $urandom_range(1, 8);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    rst_n <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_cost_limit <= 8'd0;
    in_valid <= 1'b0;
    in_adv_destination <= '0;
    in_adv_cost <= '0;
    in_sender_address <= '0;
    in_receive_interface <= '0;
    in_last_of_message <= 1'b0;
    routes_sent = 0;
    phase_limits = '{8'd16, 8'd255, 8'd1, 8'd200, 8'd255};
    foreach (neighbours[i]) neighbours[i] = $urandom;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, limit at its reset value of 255. The first beats cover
    // the address and cost extremes, saturation at the top of the cost
    // range, a kept route against a dearer offer, an equal rewrite that is
    // no change, a worse cost from the current next hop, and a cheaper route
    // from another neighbour.
    send_route(32'h0000_0000, 8'd0, HOP_A, 32'h0000_0000, 1'b0);
    send_route(32'hFFFF_FFFF, 8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    send_route(32'h0000_0000, 8'd5, HOP_B, $urandom, 1'b1);
    send_route(32'h0000_0000, 8'd0, HOP_A, $urandom, 1'b0);
    send_route(32'h0000_0000, 8'd9, HOP_A, $urandom, 1'b0);
    send_route(32'h0000_0000, 8'd3, HOP_B, $urandom, 1'b1);
    send_route(32'hFFFF_FFFF, 8'd254, HOP_B, $urandom, 1'b0);
    send_route(32'hFFFF_FFFF, 8'd100, HOP_B, $urandom, 1'b1);
    send_route(32'h0000_00FF, 8'd180, HOP_A, $urandom, 1'b1);

    // A limit of one: new routes saturate at once, and routes stored
    // above the new limit are only brought down when they are rewritten.
    set_cost_limit(8'd1);
    send_route(32'h0000_1234, 8'd0, HOP_A, $urandom, 1'b0);
    send_route(32'h8000_0000, 8'd200, HOP_C, $urandom, 1'b0);
    send_route(32'h0000_00FF, 8'd0, HOP_B, $urandom, 1'b1);
    send_route(32'h0000_0000, 8'd50, HOP_C, $urandom, 1'b1);

    // A zero limit forces every new or relaxed cost to zero; the second beat
    // is an equal rewrite that closes a message which did change.
    set_cost_limit(8'd0);
    send_route(32'hAAAA_5555, 8'd0, HOP_B, $urandom, 1'b0);
    send_route(32'hAAAA_5555, 8'd255, HOP_B, $urandom, 1'b1);
    send_route(32'h8000_0000, 8'd3, HOP_A, $urandom, 1'b1);

    set_cost_limit(8'd255);
    send_route(32'hFFFF_FFFF, 8'd254, HOP_B, $urandom, 1'b1);

    // Random part, in phases with different limits. Each limit change waits
    // for the block to drain, so the sender pauses there until every result
    // has come back. The table fills during the first phases and then stays
    // full, so later fresh destinations are dropped.
    for (int ph = 0; ph < 5; ph++) begin
      set_cost_limit(phase_limits[ph]);
      while (routes_sent < (ph + 1) * RANDOM_PER_PHASE) send_message();
    end

    drain_routes();
    repeat (150) @(posedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

[distance_vector_table_update.f]
design/dvtu_pkg.sv
design/dvtu_cell.sv
design/distance_vector_table_update.sv
design/dvtu_checker.sv
verif/route_update_checker.sv
verif/tb.sv
